// ===== src/rtp_pkg.sv =====
`timescale 1ns / 1ps

package rtp_pkg;

	localparam int FIELD_W = 20;   // Q3.16 coordinate and rate width
	localparam int SUM_W   = 40;   // x*x + y*y
	localparam int TRIAL_W = 42;   // square root trial subtrahend
	localparam int CORD_W  = 32;   // cordic datapath with guard bits
	localparam int GUARD_W = 8;
	localparam int ANG_W   = 32;   // binary angle, 2^32 units per turn
	localparam int ATAN_LEN = 24;

	// 2^32 / (2*pi) in Q32
	localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
	// cordic gain correction in Q30
	localparam logic [29:0] CORDIC_K_Q30   = 30'd652032874;

	localparam logic [ANG_W-1:0] ATAN_BAM [ATAN_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef enum logic [1:0] {
		QUAD_0   = 2'd0,
		QUAD_90  = 2'd1,
		QUAD_180 = 2'd2,
		QUAD_270 = 2'd3
	} quad_t;

	// square root cell payload, carries the point along
	typedef struct packed {
		logic [SUM_W-1:0]          rem;
		logic [FIELD_W-1:0]        root;
		logic signed [FIELD_W-1:0] x;
		logic signed [FIELD_W-1:0] y;
	} sqrt_data_t;

	// cordic cell payload
	typedef struct packed {
		logic signed [CORD_W-1:0] cx;
		logic signed [CORD_W-1:0] cy;
		logic signed [ANG_W-1:0]  z;
	} cord_data_t;

endpackage

// ===== src/radial_twist_point.sv =====
`timescale 1ns / 1ps
// throughput: one point per cycle; the whole pipeline advances together and holds
//   while the output register is full and not taken
// reset: arst_n clears all valid bits and twist_rate to zero; datapath registers are not reset
module radial_twist_point
	import rtp_pkg::*;
#(
	parameter int CORDIC_STAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// point input, tdata: x_in [19:0], y_in [39:20]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,
	// twisted point output, tdata: x_out [19:0], y_out [39:20]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,
	// twist_rate register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [19:0] cfg_data
);

	// number of micro-rotations, limited by the arctangent table
	localparam int N_CORD = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

	localparam logic [62:0] ROUND_HALF = 63'(1) << 37;

	// global advance: the output register is free or being drained
	logic en;

	logic signed [FIELD_W-1:0] rate_q;

	// stage 1: squares
	logic                      v_s1;
	logic signed [FIELD_W-1:0] x_s1, y_s1;
	logic [38:0]               xx_s1, yy_s1;
	logic signed [39:0]        sq_x, sq_y;

	// stage 2: sum of squares
	logic                      v_s2;
	logic signed [FIELD_W-1:0] x_s2, y_s2;
	logic [SUM_W-1:0]          sum_s2;

	// square root chain, one cell per result bit
	logic       sq_v [FIELD_W+1];
	sqrt_data_t sq_d [FIELD_W+1];

	// stage 3: rate * rho
	logic                      v_s3;
	logic signed [FIELD_W-1:0] x_s3, y_s3;
	logic signed [40:0]        prod_s3;

	// stage 4: partial products of the scale to binary angle
	logic                      v_s4;
	logic signed [FIELD_W-1:0] x_s4, y_s4;
	logic [49:0]               ml_s4;
	logic signed [50:0]        mh_s4;
	logic [19:0]               prod_lo;
	logic signed [20:0]        prod_hi;

	// stage 5: binary angle
	logic                      v_s5;
	logic signed [FIELD_W-1:0] x_s5, y_s5;
	logic [ANG_W-1:0]          bam_s5;
	logic signed [63:0]        mh_ext;
	logic [63:0]               bam_full;

	// stage 6 input to the cordic: quadrant pre-rotation and residual angle
	logic [ANG_W-1:0]          q_sum;
	quad_t                     quad;
	logic signed [FIELD_W:0]   rx, ry;
	logic [ANG_W-1:0]          z_res;

	logic       cd_v [N_CORD+1];
	cord_data_t cd_d [N_CORD+1];

	// stage 7: gain correction products
	logic               v_s7;
	logic signed [62:0] px_s7, py_s7;

	// output register
	logic                      out_v_q;
	logic signed [FIELD_W-1:0] x_out_q, y_out_q;

	// round half up, drop to Q3.16 and saturate
	function automatic logic signed [FIELD_W-1:0] round_sat(input logic signed [62:0] p);
		logic signed [62:0] t;
		logic signed [24:0] r;
		t = p + $signed(ROUND_HALF);
		r = t[62:38];
		if (r[24] && !(&r[23:19])) begin
			round_sat = {1'b1, {(FIELD_W-1){1'b0}}};
		end else if (!r[24] && (|r[23:19])) begin
			round_sat = {1'b0, {(FIELD_W-1){1'b1}}};
		end else begin
			round_sat = r[FIELD_W-1:0];
		end
	endfunction

	assign en        = !out_v_q || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_v_q;
	assign m_tdata   = {y_out_q, x_out_q};

	// config register; the user must write it only while the pipeline is empty, the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= '0;
		end else if (cfg_valid) begin
			rate_q <= cfg_data;
		end
	end

	// valid bits of the top-level stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s7    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1    <= s_tvalid;
			v_s2    <= v_s1;
			v_s3    <= sq_v[FIELD_W];
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_s7    <= cd_v[N_CORD];
			out_v_q <= v_s7;
		end
	end

	always_comb begin
		sq_x = 40'($signed(s_tdata[19:0])) * 40'($signed(s_tdata[19:0]));
		sq_y = 40'($signed(s_tdata[39:20])) * 40'($signed(s_tdata[39:20]));
	end

	// split the product so each multiplier stays narrow
	assign prod_lo  = prod_s3[19:0];
	assign prod_hi  = prod_s3[40:20];
	assign mh_ext   = 64'(mh_s4);
	assign bam_full = {mh_ext[43:0], 20'b0} + 64'(ml_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			// squares
			x_s1  <= s_tdata[19:0];
			y_s1  <= s_tdata[39:20];
			xx_s1 <= sq_x[38:0];
			yy_s1 <= sq_y[38:0];
			// sum
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			sum_s2 <= SUM_W'(xx_s1) + SUM_W'(yy_s1);
			// angle = rate * rho, exact Q.32 radians
			x_s3    <= sq_d[FIELD_W].x;
			y_s3    <= sq_d[FIELD_W].y;
			prod_s3 <= 41'(rate_q) * 41'($signed({1'b0, sq_d[FIELD_W].root}));
			// times 1/(2*pi) in two partial products
			x_s4  <= x_s3;
			y_s4  <= y_s3;
			ml_s4 <= 50'(prod_lo) * 50'(INV_TWO_PI_Q32);
			mh_s4 <= 51'(prod_hi) * 51'($signed({1'b0, INV_TWO_PI_Q32}));
			// binary angle, the wrap is the reduction modulo one turn
			x_s5   <= x_s4;
			y_s5   <= y_s4;
			bam_s5 <= bam_full[63:32];
			// gain correction
			px_s7 <= 63'(cd_d[N_CORD].cx) * 63'($signed({1'b0, CORDIC_K_Q30}));
			py_s7 <= 63'(cd_d[N_CORD].cy) * 63'($signed({1'b0, CORDIC_K_Q30}));
			// output register
			x_out_q <= round_sat(px_s7);
			y_out_q <= round_sat(py_s7);
		end
	end

	// square root chain, most significant result bit first
	assign sq_v[0]      = v_s2;
	assign sq_d[0].rem  = sum_s2;
	assign sq_d[0].root = '0;
	assign sq_d[0].x    = x_s2;
	assign sq_d[0].y    = y_s2;

	for (genvar k = 0; k < FIELD_W; k++) begin : g_sqrt
		rtp_sqrt_cell #(
			.BIT(FIELD_W - 1 - k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (sq_v[k]),
			.d_in     (sq_d[k]),
			.valid_out(sq_v[k+1]),
			.d_out    (sq_d[k+1])
		);
	end

	// quadrant pick: nearest multiple of 90 degrees, exact rotation by it
	always_comb begin
		q_sum = bam_s5 + (ANG_W'(1) << 29);
		quad  = quad_t'(q_sum[ANG_W-1:ANG_W-2]);
		z_res = bam_s5 - {q_sum[ANG_W-1:ANG_W-2], 30'b0};
		case (quad)
			QUAD_90: begin
				rx = -21'(y_s5);
				ry = 21'(x_s5);
			end
			QUAD_180: begin
				rx = -21'(x_s5);
				ry = -21'(y_s5);
			end
			QUAD_270: begin
				rx = 21'(y_s5);
				ry = -21'(x_s5);
			end
			default: begin
				rx = 21'(x_s5);
				ry = 21'(y_s5);
			end
		endcase
	end

	// stage 6 register holding the pre-rotated point with guard bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_v[0] <= 1'b0;
		end else if (en) begin
			cd_v[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cd_d[0].cx <= CORD_W'(rx) <<< GUARD_W;
			cd_d[0].cy <= CORD_W'(ry) <<< GUARD_W;
			cd_d[0].z  <= $signed(z_res);
		end
	end

	// cordic micro-rotation chain
	for (genvar i = 0; i < N_CORD; i++) begin : g_cordic
		rtp_cordic_cell #(
			.IDX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (cd_v[i]),
			.d_in     (cd_d[i]),
			.valid_out(cd_v[i+1]),
			.d_out    (cd_d[i+1])
		);
	end

endmodule

// ===== src/rtp_sqrt_cell.sv =====
`timescale 1ns / 1ps

// one result bit of the digit-by-digit square root
module rtp_sqrt_cell
	import rtp_pkg::*;
#(
	parameter int BIT = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       valid_in,
	input  sqrt_data_t d_in,
	output logic       valid_out,
	output sqrt_data_t d_out
);

	logic [TRIAL_W-1:0] trial;
	logic [TRIAL_W-1:0] diff;
	logic               fits;
	sqrt_data_t         d_nxt;

	always_comb begin
		trial = (TRIAL_W'(d_in.root) << (BIT + 1)) | (TRIAL_W'(1) << (2 * BIT));
		diff  = TRIAL_W'(d_in.rem) - trial;
		fits  = TRIAL_W'(d_in.rem) >= trial;
		d_nxt = d_in;
		if (fits) begin
			d_nxt.rem  = diff[SUM_W-1:0];
			d_nxt.root = d_in.root | (FIELD_W'(1) << BIT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= d_nxt;
		end
	end

endmodule

// ===== src/rtp_cordic_cell.sv =====
`timescale 1ns / 1ps

// one micro-rotation of the rotation-mode cordic
module rtp_cordic_cell
	import rtp_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       valid_in,
	input  cord_data_t d_in,
	output logic       valid_out,
	output cord_data_t d_out
);

	logic signed [CORD_W-1:0] dx;
	logic signed [CORD_W-1:0] dy;
	logic signed [ANG_W-1:0]  atan_v;
	cord_data_t               d_nxt;

	always_comb begin
		dx     = d_in.cy >>> IDX;
		dy     = d_in.cx >>> IDX;
		atan_v = $signed(ATAN_BAM[IDX]);
		if (!d_in.z[ANG_W-1]) begin
			d_nxt.cx = d_in.cx - dx;
			d_nxt.cy = d_in.cy + dy;
			d_nxt.z  = d_in.z - atan_v;
		end else begin
			d_nxt.cx = d_in.cx + dx;
			d_nxt.cy = d_in.cy - dy;
			d_nxt.z  = d_in.z + atan_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= d_nxt;
		end
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import rtp_pkg::*;

	localparam int NUM_STAGES = 16;
	localparam int STAGES_USED = (NUM_STAGES > 24) ? 24 : NUM_STAGES;
	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 28 + NUM_STAGES + 16;
	localparam int PHASE_POINTS = 244;

	localparam logic signed [19:0] Q_MAX = 20'sh7FFFF;
	localparam logic signed [19:0] Q_MIN = -20'sh80000;

	// turns per radian in Q32, binary angle units
	localparam longint unsigned TURN_PER_RAD = 64'd683565276;
	// cordic gain compensation, Q30
	localparam longint GAIN_Q30 = 64'sd652032874;

	localparam logic [31:0] ARCTAN_TURN [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// x in the low half, as on the bus
	typedef struct packed {
		logic signed [19:0] y;
		logic signed [19:0] x;
	} point_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // x_in [19:0], y_in [39:20]
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // x_out [19:0], y_out [39:20]
	logic        cfg_valid;
	logic        cfg_ready;
	logic [19:0] cfg_data;

	logic signed [19:0] rate_now;
	point_t             pending_twists[$];
	int unsigned        error_count;
	int unsigned        cycle_count;
	bit                 src_idle;
	bit                 sink_idle;

	radial_twist_point #(
		.CORDIC_STAGES(NUM_STAGES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// gain compensation, round half up, clamp to Q3.16
	function automatic logic signed [19:0] gain_sat(input longint v);
		longint r;
		r = (v * GAIN_Q30 + (64'sd1 <<< 37)) >>> 38;
		if (r < longint'(Q_MIN))
			r = Q_MIN;
		if (r > longint'(Q_MAX))
			r = Q_MAX;
		return r[19:0];
	endfunction

	// rotate the point by rate * radius
	function automatic point_t twist_point(input point_t p, input logic signed [19:0] rate);
		longint            px, py, tmp, cx, cy, dx, dy, prod, z;
		longint unsigned   sum, root, probe, turn;
		logic [31:0]       resid;
		int unsigned       quad;
		point_t            res;
		px = p.x;
		py = p.y;
		// integer square root of x^2 + y^2
		sum = $unsigned(px * px) + $unsigned(py * py);
		root = 0;
		probe = 64'd1 << 40;
		while (probe > sum)
			probe >>= 2;
		while (probe != 0) begin
			if (sum >= root + probe) begin
				sum -= root + probe;
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		// radians Q32 to binary angle, wraps once per turn
		prod = longint'(rate) * $signed(root);
		turn = $unsigned(prod) * TURN_PER_RAD;
		turn = (turn >> 32) & 64'hFFFF_FFFF;
		quad = 32'(((turn + 64'h2000_0000) >> 30) & 64'd3);
		resid = turn[31:0] - (32'(quad) << 30);
		z = $signed(resid);
		case (quad_t'(quad))
			QUAD_90: begin
				tmp = px;
				px = -py;
				py = tmp;
			end
			QUAD_180: begin
				px = -px;
				py = -py;
			end
			QUAD_270: begin
				tmp = px;
				px = py;
				py = -tmp;
			end
			default: ;
		endcase
		cx = px <<< 8;
		cy = py <<< 8;
		for (int i = 0; i < STAGES_USED; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (z >= 0) begin
				cx -= dx;
				cy += dy;
				z -= longint'(ARCTAN_TURN[i]);
			end else begin
				cx += dx;
				cy -= dy;
				z += longint'(ARCTAN_TURN[i]);
			end
		end
		res.x = gain_sat(cx);
		res.y = gain_sat(cy);
		return res;
	endfunction

	function automatic logic signed [19:0] rand_coord();
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: v = int'($urandom);
			5, 6, 7: v = int'($urandom_range(0, 131071)) - 65536;
			default: begin
				case ($urandom_range(0, 3))
					0: v = Q_MIN;
					1: v = Q_MAX;
					2: v = 0;
					default: v = -1;
				endcase
			end
		endcase
		return v[19:0];
	endfunction

	// one point over the input stream; expectation queued at the transfer
	task automatic send_point(input logic signed [19:0] px, input logic signed [19:0] py);
		int unsigned gap;
		point_t      p;
		p.x = px;
		p.y = py;
		gap = src_idle ? $urandom_range(0, 3) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= p;
		do @(posedge clk); while (!s_tready);
		pending_twists = {pending_twists, twist_point(p, rate_now)};
	endtask

	// stop the stream and let every twisted point come back
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending_twists.size() == 0);
	endtask

	task automatic write_twist_rate(input logic signed [19:0] r);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= r;
		do @(posedge clk); while (!cfg_ready);
		rate_now = r;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// reset value of the rate: cordic runs with no rotation
	task automatic test_zero_twist();
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		send_point(20'sd0, 20'sd0);
		send_point(Q_MAX, 20'sd0);
		send_point(Q_MIN, 20'sd0);
		send_point(20'sd0, Q_MAX);
		send_point(20'sd0, Q_MIN);
		send_point(Q_MAX, Q_MAX);
		send_point(Q_MIN, Q_MIN);
		send_point(20'sd1, -20'sd1);
	endtask

	task automatic test_rate_extremes();
		write_twist_rate(Q_MAX);
		send_point(20'sd65536, 20'sd0);
		send_point(Q_MAX, Q_MIN);
		send_point(Q_MIN, Q_MAX);
		send_point(20'sd12345, -20'sd54321);
		write_twist_rate(Q_MIN);
		send_point(20'sd65536, 20'sd0);
		send_point(Q_MAX, Q_MIN);
		send_point(Q_MIN, Q_MAX);
		send_point(20'sd12345, -20'sd54321);
	endtask

	// about 45 degrees at the corner radius pushes one coordinate past full scale
	task automatic test_saturation();
		write_twist_rate(20'sd4550);
		send_point(Q_MAX, Q_MAX);
		send_point(Q_MIN, Q_MIN);
		send_point(Q_MAX, Q_MIN);
		send_point(Q_MIN, Q_MAX);
	endtask

	task automatic test_random_stream();
		logic signed [19:0] r;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: r = 20'($urandom);
				1: r = 20'sd0;
				2: r = Q_MAX;
				3: r = Q_MIN;
				4, 5: r = 20'(int'($urandom_range(0, 8191)) - 4096);
				default: r = 20'($urandom);
			endcase
			write_twist_rate(r);
			// both stalling, none, source only, sink only
			src_idle  = (phase % 4 == 0) || (phase % 4 == 2);
			sink_idle = (phase % 4 == 0) || (phase % 4 == 3);
			for (int n = 0; n < PHASE_POINTS; n++)
				send_point(rand_coord(), rand_coord());
		end
		src_idle  = 1'b1;
		sink_idle = 1'b1;
	endtask

	// result checker
	always @(posedge clk) begin
		point_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_twists.size() == 0) begin
				$error("twisted point %h arrived with no point pending", m_tdata);
				error_count++;
			end else begin
				want = pending_twists.pop_front();
				if (got.x !== want.x) begin
					$error("x_out mismatch: expected %0d, got %0d", want.x, got.x);
					error_count++;
				end
				if (got.y !== want.y) begin
					$error("y_out mismatch: expected %0d, got %0d", want.y, got.y);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// sink side backpressure, one draw per transfer
	initial begin
		int unsigned stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = sink_idle ? $urandom_range(0, 3) : 0;
			if (stall > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		rate_now    = '0;
		error_count = 0;
		cycle_count = 0;
		src_idle    = 1'b1;
		sink_idle   = 1'b1;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_zero_twist();
		test_rate_extremes();
		test_saturation();
		test_random_stream();

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
